// ----- hdl/tpgc_pkg.sv -----
// Package for the two-player game clock: request and result structs,
// command and register codes, and timing constants. No dependencies.
package tpgc_pkg;

  localparam int unsigned MS_PER_SECOND = 1000;

  // Added before the divide so that the quotient rounds up.
  localparam logic [9:0] ROUND_UP_MS = 10'(MS_PER_SECOND - 1);

  // Seconds-left value reported while counting up.
  localparam logic [31:0] COUNT_UP_SECONDS = 32'd3999999999;

  // (ms + 999) is divided by 8 first, then by 125 through a reciprocal:
  // floor(y / 125) == (y * RECIP_MULT) >> RECIP_SHIFT for every y below 2**30.
  localparam int unsigned RECIP_SHIFT = 37;
  localparam logic [30:0] RECIP_MULT  = 31'd1099511628;
  localparam int unsigned PRE_SHIFT   = 3;
  localparam int unsigned SCALED_W    = 33 - PRE_SHIFT;

  // Configuration register reset values.
  localparam logic [15:0] START_SECONDS_RESET     = 16'd300;
  localparam logic [11:0] INCREMENT_SECONDS_RESET = 12'd0;
  localparam logic        COUNT_DOWN_RESET        = 1'b1;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_PAUSE  = 3'd2,
    FUNC_RESUME = 3'd3,
    FUNC_STOP   = 3'd4,
    FUNC_SELECT = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } clock_mode_t;

  typedef enum logic [2:0] {
    CFG_FIRST_START      = 3'd0,
    CFG_FIRST_INCREMENT  = 3'd1,
    CFG_SECOND_START     = 3'd2,
    CFG_SECOND_INCREMENT = 3'd3,
    CFG_COUNT_DOWN       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] func;
    logic       player;
  } cmd_t;

  typedef struct packed {
    logic        turn_now;
    logic [1:0]  clock_mode_now;
    logic [31:0] first_reading_ms;
    logic [31:0] second_reading_ms;
    logic [31:0] first_seconds_left;
    logic [31:0] second_seconds_left;
  } res_t;

endpackage

// ----- hdl/tpgc_ceil_sec.sv -----
// Converts a pre-rounded, pre-shifted millisecond count to whole seconds.
// Depends on tpgc_pkg for the reciprocal constants.
module tpgc_ceil_sec (
  input  logic [tpgc_pkg::SCALED_W-1:0] scaled_ms,
  output logic [31:0]                   seconds
);

  localparam int unsigned PROD_W = tpgc_pkg::SCALED_W + 31;

  logic [PROD_W-1:0] product;

  // One 30 by 31 bit multiply by the reciprocal of 125; the quotient is exact
  // over the whole input range, so no correction step follows.
  assign product = PROD_W'(scaled_ms) * PROD_W'(tpgc_pkg::RECIP_MULT);
  assign seconds = 32'(product[PROD_W-1:tpgc_pkg::RECIP_SHIFT]);

endmodule

// ----- hdl/two_player_game_clock.sv -----
// Top level of the two-player game clock with per-player increment.
// Depends on tpgc_pkg and instantiates tpgc_ceil_sec twice.
//
//   channel  handshake                payload              role
//   cmd      cmd_valid / cmd_ready    cmd (cmd_t)          one command request
//   res      res_valid / res_ready    res (res_t)          one result per request
//   cfg      cfg_valid / cfg_ready    cfg_index, cfg_data  register write request
//
// Every command request yields one result, and a new request is accepted in
// every cycle while res_ready does not hold the pipeline. The clock state
// registers take the update at acceptance, the next stage forms readings and the
// rounded remaining time, and the last stage divides by 1000 through a
// reciprocal multiply into the result register.
// The three stages advance together; when a result waits on res_ready the
// whole pipeline holds and cmd_ready drops. cfg_ready is always high.
// Reset (rst, synchronous) empties the pipeline, stops both clocks, clears
// budgets and elapsed counts, and restores the register defaults.
module two_player_game_clock (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  tpgc_pkg::cmd_t       cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tpgc_pkg::res_t       res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers, one per player where the option is per player.
  logic [15:0] start_seconds [2];
  logic [11:0] increment_seconds [2];
  logic        count_down;

  // Clock state. These registers also serve as the first pipeline stage.
  logic [31:0]           budget [2];
  logic [31:0]           elapsed [2];
  logic                  turn;
  tpgc_pkg::clock_mode_t run_state;
  logic [31:0]           budget_next [2];
  logic [31:0]           elapsed_next [2];
  logic                  turn_next;
  tpgc_pkg::clock_mode_t run_state_next;

  // Second stage: readings and rounded remaining time.
  logic                           s1_valid;
  logic                           s2_valid;
  logic                           s2_turn;
  logic [1:0]                     s2_mode;
  logic [31:0]                    s2_reading [2];
  logic                           s2_expired [2];
  logic [tpgc_pkg::SCALED_W-1:0]  s2_scaled [2];

  logic                           advance;
  logic                           cmd_accept;
  logic [31:0]                    seconds [2];

  assign advance    = !res_valid || res_ready;
  assign cmd_ready  = advance;
  assign cmd_accept = cmd_valid && cmd_ready;
  assign cfg_ready  = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_seconds[0]     <= tpgc_pkg::START_SECONDS_RESET;
      start_seconds[1]     <= tpgc_pkg::START_SECONDS_RESET;
      increment_seconds[0] <= tpgc_pkg::INCREMENT_SECONDS_RESET;
      increment_seconds[1] <= tpgc_pkg::INCREMENT_SECONDS_RESET;
      count_down           <= tpgc_pkg::COUNT_DOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpgc_pkg::CFG_FIRST_START:      start_seconds[0]     <= cfg_data;
        tpgc_pkg::CFG_FIRST_INCREMENT:  increment_seconds[0] <= cfg_data[11:0];
        tpgc_pkg::CFG_SECOND_START:     start_seconds[1]     <= cfg_data;
        tpgc_pkg::CFG_SECOND_INCREMENT: increment_seconds[1] <= cfg_data[11:0];
        tpgc_pkg::CFG_COUNT_DOWN:       count_down           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next clock state for one command. Counters saturate instead of wrapping.
  always_comb begin
    logic [32:0] inc_sum;
    inc_sum        = 33'(budget[turn]) + 33'(32'(increment_seconds[turn]) *
                     32'(tpgc_pkg::MS_PER_SECOND));
    budget_next    = budget;
    elapsed_next   = elapsed;
    turn_next      = turn;
    run_state_next = run_state;
    unique case (cmd.func)
      tpgc_pkg::FUNC_TICK: begin
        if (run_state == tpgc_pkg::MODE_RUNNING && elapsed[turn] != '1) begin
          elapsed_next[turn] = elapsed[turn] + 32'd1;
        end
      end
      tpgc_pkg::FUNC_START: begin
        if (run_state != tpgc_pkg::MODE_RUNNING) begin
          budget_next[0]  = 32'(start_seconds[0]) * 32'(tpgc_pkg::MS_PER_SECOND);
          budget_next[1]  = 32'(start_seconds[1]) * 32'(tpgc_pkg::MS_PER_SECOND);
          elapsed_next[0] = '0;
          elapsed_next[1] = '0;
          run_state_next  = tpgc_pkg::MODE_RUNNING;
        end
      end
      tpgc_pkg::FUNC_PAUSE: begin
        if (run_state == tpgc_pkg::MODE_RUNNING) begin
          run_state_next = tpgc_pkg::MODE_PAUSED;
        end
      end
      tpgc_pkg::FUNC_RESUME: begin
        if (run_state == tpgc_pkg::MODE_PAUSED) begin
          run_state_next = tpgc_pkg::MODE_RUNNING;
        end
      end
      tpgc_pkg::FUNC_STOP: begin
        run_state_next = tpgc_pkg::MODE_STOPPED;
      end
      tpgc_pkg::FUNC_SELECT: begin
        // Passing the turn while running credits the outgoing player.
        if (cmd.player != turn) begin
          if (run_state == tpgc_pkg::MODE_RUNNING) begin
            budget_next[turn] = inc_sum[32] ? '1 : inc_sum[31:0];
          end
          turn_next = cmd.player;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget[0]  <= '0;
      budget[1]  <= '0;
      elapsed[0] <= '0;
      elapsed[1] <= '0;
      turn       <= 1'b0;
      run_state  <= tpgc_pkg::MODE_STOPPED;
    end else if (cmd_accept) begin
      budget    <= budget_next;
      elapsed   <= elapsed_next;
      turn      <= turn_next;
      run_state <= run_state_next;
    end
  end

  // Pipeline occupancy. All stages move together on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd_accept;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  // Second stage. The remaining time gets 999 added for rounding up and is
  // pre-shifted by three so that the divide by 1000 becomes one by 125.
  always_ff @(posedge clk) begin
    logic [32:0] sum;
    logic [31:0] diff;
    logic [32:0] rounded;
    if (advance) begin
      s2_turn <= turn;
      s2_mode <= run_state;
      for (int p = 0; p < 2; p++) begin
        sum     = 33'(elapsed[p]) + 33'(budget[p]);
        diff    = budget[p] - elapsed[p];
        rounded = 33'(diff) + 33'(tpgc_pkg::ROUND_UP_MS);
        s2_reading[p] <= count_down ? elapsed[p] : (sum[32] ? '1 : sum[31:0]);
        s2_expired[p] <= elapsed[p] >= budget[p];
        s2_scaled[p]  <= rounded[32:tpgc_pkg::PRE_SHIFT];
      end
    end
  end

  tpgc_ceil_sec u_sec_first (
    .scaled_ms (s2_scaled[0]),
    .seconds   (seconds[0])
  );

  tpgc_ceil_sec u_sec_second (
    .scaled_ms (s2_scaled[1]),
    .seconds   (seconds[1])
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res.turn_now          <= s2_turn;
      res.clock_mode_now    <= s2_mode;
      res.first_reading_ms  <= s2_reading[0];
      res.second_reading_ms <= s2_reading[1];
      res.first_seconds_left <= !count_down ? tpgc_pkg::COUNT_UP_SECONDS :
                                (s2_expired[0] ? '0 : seconds[0]);
      res.second_seconds_left <= !count_down ? tpgc_pkg::COUNT_UP_SECONDS :
                                 (s2_expired[1] ? '0 : seconds[1]);
    end
  end

`ifndef NO_ASSERTIONS
  // A tick accepted while running advances the clock in turn by one, unless
  // it has already saturated.
  assert property (@(posedge clk) disable iff (rst)
    cmd_accept && cmd.func == tpgc_pkg::FUNC_TICK &&
    run_state == tpgc_pkg::MODE_RUNNING && elapsed[turn] != '1
    |=> elapsed[$past(turn)] == $past(elapsed[turn]) + 32'd1)
    else $error("tick did not advance the running clock");

  // A start accepted while not running leaves both counts cleared and the
  // clock running.
  assert property (@(posedge clk) disable iff (rst)
    cmd_accept && cmd.func == tpgc_pkg::FUNC_START &&
    run_state != tpgc_pkg::MODE_RUNNING
    |=> elapsed[0] == '0 && elapsed[1] == '0 &&
        run_state == tpgc_pkg::MODE_RUNNING)
    else $error("start did not restart the clock");

  // Budgets only shrink through a start.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd_accept && cmd.func == tpgc_pkg::FUNC_START)
    |=> budget[0] >= $past(budget[0]) && budget[1] >= $past(budget[1]))
    else $error("budget decreased without a start");
`endif

endmodule
